[design/gda_pkg.sv]
// Package for the Gregorian date arithmetic block.
// Holds operation codes, sequencer states, ALU control types and calendar helpers.
// No dependencies.
package gda_pkg;

  localparam int YEAR_MAX_DEF    = 9999;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int ACC_W      = 25;   // signed accumulator, covers day numbers and counts
  localparam int YEAR_W     = 14;
  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int BETWEEN_W  = 22;
  localparam int CNT_PORT_W = 16;
  localparam int MOD_W      = 9;    // year mod 400

  localparam int YEAR_CYCLE = 400;
  localparam int CENTURY    = 100;
  localparam int DAYS_YEAR  = 365;
  localparam int DAYS_LEAP  = 366;
  localparam int MONTHS     = 12;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_NEXT = 3'd2,
    OP_PREV = 3'd3,
    OP_DIFF = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P400,
    ST_P100,
    ST_NORM,
    ST_DBY,
    ST_MSUM,
    ST_DAY,
    ST_STEP,
    ST_YFWD,
    ST_YBWD,
    ST_MDIV,
    ST_ABS,
    ST_DONE
  } state_e;

  // terms of days-before-year: p*365 + p/4 - 3*(p/400) - (p mod 400)/100
  typedef enum logic [3:0] {
    DB_P256,
    DB_P64,
    DB_P32,
    DB_P8,
    DB_P4,
    DB_P1,
    DB_Q4,
    DB_C400X2,
    DB_C400,
    DB_C100
  } dby_step_e;

  typedef enum logic [1:0] {
    A_ACC,
    A_REM,
    A_ZERO
  } a_sel_e;

  typedef struct packed {
    a_sel_e           a_sel;
    logic             sub;
    logic [ACC_W-1:0] b;
  } alu_ctrl_t;

  function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MONTH_W-1:0] idx);
    logic [DAY_W-1:0] len;
    unique case (idx)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // leap rule evaluated on year mod 400
  function automatic logic leap_of_mod(input logic [MOD_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != MOD_W'(CENTURY)) && (r != MOD_W'(2 * CENTURY))
           && (r != MOD_W'(3 * CENTURY));
  endfunction

  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    r = m;
    if (m == '0) r = 4'd1;
    if (m > MONTH_W'(MONTHS)) r = MONTH_W'(MONTHS);
    return r;
  endfunction

endpackage

[design/gda_alu.sv]
// Shared add/subtract unit of the date sequencer.
// Selects the A operand, adds or subtracts B, flags a negative result.
// Depends on gda_pkg.
module gda_alu import gda_pkg::*; (
  input  logic [ACC_W-1:0] acc_i,
  input  logic [ACC_W-1:0] rem_i,
  input  alu_ctrl_t        ctrl_i,
  output logic [ACC_W-1:0] sum_o,
  output logic             neg_o
);

  logic [ACC_W-1:0] a;

  always_comb begin
    unique case (ctrl_i.a_sel)
      A_ACC:   a = acc_i;
      A_REM:   a = rem_i;
      default: a = '0;
    endcase
  end

  assign sum_o = a + (ctrl_i.b ^ {ACC_W{ctrl_i.sub}}) + ACC_W'(ctrl_i.sub);
  assign neg_o = sum_o[ACC_W-1];

endmodule

[design/gregorian_date_arithmetic.sv]
// Gregorian date arithmetic: add/subtract days, next/previous day, day difference.
// Top level: sequencer and working registers around one shared adder (gda_alu).
// Depends on gda_pkg and gda_alu.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------------------
//  request   | start_i, busy_o       | op_i, day/month/year_a_i, day/month/year_b_i,
//            |                       | day_count_i
//  result    | done_o (1-cycle pulse) | day_out_o, month_out_o, year_out_o,
//            |                       | days_between_o, out_of_range_o
//
// A request transfers when start_i is high and busy_o is low; busy_o stays high through the
// result pulse. Every arithmetic step goes through the shared adder, one operation per cycle.
// Add/sub/next/prev: mod-400 steps, century steps (up to 3), start month sum, day, step, a year
// step per year crossed (up to 180 years for a 65535-day count) and the end month search.
// Difference: per date, mod-400/mod-100 reduction, the ten-term year count, month sum and day,
// then the absolute value. Bad years and spare op codes finish after the reduction.
// Reset clears the sequencer only. The receiver cannot stall; done_o lasts one cycle.
module gregorian_date_arithmetic import gda_pkg::*; #(
  parameter int YEAR_MAX    = YEAR_MAX_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [2:0]            op_i,
  input  logic [DAY_W-1:0]      day_a_i,
  input  logic [MONTH_W-1:0]    month_a_i,
  input  logic [YEAR_W-1:0]     year_a_i,
  input  logic [DAY_W-1:0]      day_b_i,
  input  logic [MONTH_W-1:0]    month_b_i,
  input  logic [YEAR_W-1:0]     year_b_i,
  input  logic [CNT_PORT_W-1:0] day_count_i,
  output logic                  done_o,
  output logic [DAY_W-1:0]      day_out_o,
  output logic [MONTH_W-1:0]    month_out_o,
  output logic [YEAR_W-1:0]     year_out_o,
  output logic [BETWEEN_W-1:0]  days_between_o,
  output logic                  out_of_range_o
);

  localparam int CntW  = (COUNT_WIDTH < CNT_PORT_W) ? COUNT_WIDTH : CNT_PORT_W;
  localparam int YrClg = $clog2(YEAR_MAX + 1);
  localparam int YW    = (YrClg > 15) ? YrClg : 15;

  state_e               state_q, state_d;
  logic [2:0]           op_q, op_d;
  logic [DAY_W-1:0]     d_q [2], d_d [2];
  logic [MONTH_W-1:0]   m_q [2], m_d [2];
  logic [YEAR_W-1:0]    y_q [2], y_d [2];
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 side_q, side_d;
  logic [YEAR_W-1:0]    rem_q, rem_d;
  logic [5:0]           c400_q, c400_d;
  logic [1:0]           c100_q, c100_d;
  logic [MOD_W-1:0]     ymod_q, ymod_d;
  logic [YW-1:0]        wy_q, wy_d;
  logic [MONTH_W-1:0]   j_q, j_d;
  dby_step_e            k_q, k_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [DAY_W-1:0]     res_d_q, res_d_d;
  logic [MONTH_W-1:0]   res_m_q, res_m_d;
  logic [YEAR_W-1:0]    res_y_q, res_y_d;
  logic [BETWEEN_W-1:0] btw_q, btw_d;
  logic                 flag_q, flag_d;

  alu_ctrl_t            alu_ctrl;
  logic [ACC_W-1:0]     alu_sum;
  logic                 alu_neg;

  logic [MOD_W-1:0]     mod_next, mod_prev;
  logic                 leap_cur, leap_prev;
  logic                 ok_a, ok_b;
  logic [YEAR_W-1:0]    p_year;
  logic [ACC_W-1:0]     p_w;
  logic                 step_down;

  gda_alu u_alu (
    .acc_i  (acc_q),
    .rem_i  (ACC_W'(rem_q)),
    .ctrl_i (alu_ctrl),
    .sum_o  (alu_sum),
    .neg_o  (alu_neg)
  );

  assign mod_next  = (ymod_q == MOD_W'(YEAR_CYCLE - 1)) ? '0 : ymod_q + 9'd1;
  assign mod_prev  = (ymod_q == '0) ? MOD_W'(YEAR_CYCLE - 1) : ymod_q - 9'd1;
  assign leap_cur  = leap_of_mod(ymod_q);
  assign leap_prev = leap_of_mod(mod_prev);
  assign ok_a      = (y_q[0] != '0) && (YW'(y_q[0]) <= YW'(YEAR_MAX));
  assign ok_b      = (y_q[1] != '0) && (YW'(y_q[1]) <= YW'(YEAR_MAX));
  assign p_year    = y_q[side_q] - 14'd1;
  assign p_w       = ACC_W'(p_year);
  assign step_down = (op_q == OP_SUB) || (op_q == OP_PREV);

  always_comb begin
    logic [DAY_W-1:0]  last;
    logic [YEAR_W-1:0] prep_y;
    logic              prep;
    state_d  = state_q;
    op_d     = op_q;
    d_d      = d_q;
    m_d      = m_q;
    y_d      = y_q;
    cnt_d    = cnt_q;
    side_d   = side_q;
    rem_d    = rem_q;
    c400_d   = c400_q;
    c100_d   = c100_q;
    ymod_d   = ymod_q;
    wy_d     = wy_q;
    j_d      = j_q;
    k_d      = k_q;
    acc_d    = acc_q;
    res_d_d  = res_d_q;
    res_m_d  = res_m_q;
    res_y_d  = res_y_q;
    btw_d    = btw_q;
    flag_d   = flag_q;
    alu_ctrl = '{a_sel: A_ACC, sub: 1'b0, b: '0};
    last     = month_len(leap_cur, m_q[side_q] - 4'd1);
    prep     = 1'b0;
    prep_y   = year_a_i;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          d_d[0]  = (day_a_i == '0) ? 5'd1 : day_a_i;
          d_d[1]  = (day_b_i == '0) ? 5'd1 : day_b_i;
          m_d[0]  = clamp_month(month_a_i);
          m_d[1]  = clamp_month(month_b_i);
          y_d[0]  = year_a_i;
          y_d[1]  = year_b_i;
          cnt_d   = day_count_i[CntW-1:0];
          side_d  = 1'b0;
          prep    = 1'b1;
          prep_y  = year_a_i;
          state_d = ST_P400;
        end
      end
      ST_P400: begin
        alu_ctrl = '{a_sel: A_REM, sub: 1'b1, b: ACC_W'(YEAR_CYCLE)};
        if (!alu_neg) begin
          rem_d  = alu_sum[YEAR_W-1:0];
          c400_d = c400_q + 6'd1;
        end else begin
          // rem holds (y-1) mod 400 here
          ymod_d  = (rem_q == YEAR_W'(YEAR_CYCLE - 1)) ? '0 : rem_q[MOD_W-1:0] + 9'd1;
          state_d = ST_P100;
        end
      end
      ST_P100: begin
        alu_ctrl = '{a_sel: A_REM, sub: 1'b1, b: ACC_W'(CENTURY)};
        if (!alu_neg) begin
          rem_d  = alu_sum[YEAR_W-1:0];
          c100_d = c100_q + 2'd1;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (d_q[side_q] > last) d_d[side_q] = last;
        k_d = DB_P256;
        j_d = '0;
        if (!side_q) begin
          res_d_d = (d_q[0] > last) ? last : d_q[0];
          res_m_d = m_q[0];
          res_y_d = y_q[0];
          btw_d   = '0;
          flag_d  = 1'b0;
          acc_d   = '0;
          priority if (op_q > OP_DIFF) begin
            state_d = ST_DONE;
          end else if (!ok_a || (op_q == OP_DIFF && !ok_b)) begin
            flag_d  = 1'b1;
            state_d = ST_DONE;
          end else if (op_q == OP_DIFF) begin
            state_d = ST_DBY;
          end else begin
            state_d = ST_MSUM;
          end
        end else begin
          state_d = ST_DBY;
        end
      end
      ST_DBY: begin
        alu_ctrl.a_sel = A_ACC;
        alu_ctrl.sub   = side_q;
        unique case (k_q)
          DB_P256:   alu_ctrl.b = p_w << 8;
          DB_P64:    alu_ctrl.b = p_w << 6;
          DB_P32:    alu_ctrl.b = p_w << 5;
          DB_P8:     alu_ctrl.b = p_w << 3;
          DB_P4:     alu_ctrl.b = p_w << 2;
          DB_P1:     alu_ctrl.b = p_w;
          DB_Q4:     alu_ctrl.b = ACC_W'(p_year[YEAR_W-1:2]);
          DB_C400X2: begin
            alu_ctrl.b   = ACC_W'({c400_q, 1'b0});
            alu_ctrl.sub = !side_q;
          end
          DB_C400:   begin
            alu_ctrl.b   = ACC_W'(c400_q);
            alu_ctrl.sub = !side_q;
          end
          default:   begin
            alu_ctrl.b   = ACC_W'(c100_q);
            alu_ctrl.sub = !side_q;
          end
        endcase
        acc_d = alu_sum;
        if (k_q == DB_C100) begin
          state_d = ST_MSUM;
        end else begin
          k_d = dby_step_e'(k_q + 4'd1);
        end
      end
      ST_MSUM: begin
        alu_ctrl = '{a_sel: A_ACC, sub: side_q, b: ACC_W'(month_len(leap_cur, j_q))};
        if ((5'(j_q) + 5'd1) < 5'(m_q[side_q])) begin
          acc_d = alu_sum;
          j_d   = j_q + 4'd1;
        end else begin
          state_d = ST_DAY;
        end
      end
      ST_DAY: begin
        alu_ctrl = '{a_sel: A_ACC, sub: side_q, b: ACC_W'(d_q[side_q] - 5'd1)};
        acc_d    = alu_sum;
        if (op_q == OP_DIFF) begin
          if (!side_q) begin
            side_d  = 1'b1;
            prep    = 1'b1;
            prep_y  = y_q[1];
            state_d = ST_P400;
          end else begin
            state_d = ST_ABS;
          end
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        alu_ctrl.a_sel = A_ACC;
        alu_ctrl.sub   = step_down;
        alu_ctrl.b     = (op_q == OP_ADD || op_q == OP_SUB) ? ACC_W'(cnt_q) : ACC_W'(1);
        acc_d   = alu_sum;
        wy_d    = YW'(y_q[0]);
        state_d = step_down ? ST_YBWD : ST_YFWD;
      end
      ST_YFWD: begin
        alu_ctrl = '{a_sel: A_ACC, sub: 1'b1,
                     b: ACC_W'(leap_cur ? DAYS_LEAP : DAYS_YEAR)};
        j_d = '0;
        if (!alu_neg) begin
          if (wy_q == YW'(YEAR_MAX)) begin
            flag_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            acc_d  = alu_sum;
            wy_d   = wy_q + 1'b1;
            ymod_d = mod_next;
          end
        end else begin
          state_d = ST_MDIV;
        end
      end
      ST_YBWD: begin
        // borrow a whole year: the added length is that of the year stepped into
        alu_ctrl = '{a_sel: A_ACC, sub: 1'b0,
                     b: ACC_W'(leap_prev ? DAYS_LEAP : DAYS_YEAR)};
        j_d = '0;
        if (acc_q[ACC_W-1]) begin
          if (wy_q == YW'(1)) begin
            flag_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            acc_d  = alu_sum;
            wy_d   = wy_q - 1'b1;
            ymod_d = mod_prev;
          end
        end else begin
          state_d = ST_MDIV;
        end
      end
      ST_MDIV: begin
        alu_ctrl = '{a_sel: A_ACC, sub: 1'b1, b: ACC_W'(month_len(leap_cur, j_q))};
        if (j_q < MONTH_W'(MONTHS - 1) && !alu_neg) begin
          acc_d = alu_sum;
          j_d   = j_q + 4'd1;
        end else begin
          res_d_d = acc_q[DAY_W-1:0] + 5'd1;
          res_m_d = j_q + 4'd1;
          res_y_d = wy_q[YEAR_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_ABS: begin
        alu_ctrl = '{a_sel: A_ZERO, sub: acc_q[ACC_W-1], b: acc_q};
        btw_d    = alu_sum[BETWEEN_W-1:0];
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (prep) begin
      // year 0 is taken as 400k so its leap test comes out right
      rem_d  = (prep_y == '0) ? YEAR_W'(YEAR_CYCLE - 1) : prep_y - 14'd1;
      c400_d = '0;
      c100_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    d_q     <= d_d;
    m_q     <= m_d;
    y_q     <= y_d;
    cnt_q   <= cnt_d;
    side_q  <= side_d;
    rem_q   <= rem_d;
    c400_q  <= c400_d;
    c100_q  <= c100_d;
    ymod_q  <= ymod_d;
    wy_q    <= wy_d;
    j_q     <= j_d;
    k_q     <= k_d;
    acc_q   <= acc_d;
    res_d_q <= res_d_d;
    res_m_q <= res_m_d;
    res_y_q <= res_y_d;
    btw_q   <= btw_d;
    flag_q  <= flag_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = (state_q == ST_DONE);
  assign day_out_o      = res_d_q;
  assign month_out_o    = res_m_q;
  assign year_out_o     = res_y_q;
  assign days_between_o = btw_q;
  assign out_of_range_o = flag_q;

  ap_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request transfer did not raise busy");

  ap_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  ap_between_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (op_q != OP_DIFF) |-> days_between_o == '0)
    else $error("nonzero day difference outside difference operation");

  ap_range_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> year_out_o == y_q[0] && month_out_o == m_q[0])
    else $error("out-of-range result does not hold the first date");

  ap_month_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> month_out_o != '0 && month_out_o <= MONTH_W'(MONTHS))
    else $error("result month out of 1..12");

endmodule
